// ===== sv/igew_pkg.sv =====
// ----------------------------------------------------------------------------
// igew_pkg
// Shared widths, register indexes and weight mode codes for the pixel grid
// edge weight block.
// ----------------------------------------------------------------------------
package igew_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int INDEX_BITS     = 24;
  localparam int WEIGHT_BITS    = PIXEL_BITS + 1;
  localparam int SIZE_BITS      = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_index_t REG_WEIGHT_MODE  = 2'd2;

  localparam logic MODE_DIFFERENCE = 1'b0;
  localparam logic MODE_AVERAGE    = 1'b1;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd4096;

endpackage

// ===== sv/igew_pixel_if.sv =====
// ----------------------------------------------------------------------------
// igew_pixel_if
// Pixel input channel: valid/ready handshake with one pixel sample per beat.
// ----------------------------------------------------------------------------
interface igew_pixel_if;

  logic                           valid;
  logic                           ready;
  logic [igew_pkg::PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);

endinterface

// ===== sv/igew_vertex_if.sv =====
// ----------------------------------------------------------------------------
// igew_vertex_if
// Vertex output channel: one vertex with its left and upper edges per beat.
// ----------------------------------------------------------------------------
interface igew_vertex_if;

  logic                             valid;
  logic                             ready;
  logic [igew_pkg::INDEX_BITS-1:0]  vertex_index;
  logic [igew_pkg::PIXEL_BITS-1:0]  vertex_value;
  logic                             left_valid;
  logic [igew_pkg::WEIGHT_BITS-1:0] left_weight;
  logic                             up_valid;
  logic [igew_pkg::WEIGHT_BITS-1:0] up_weight;
  logic                             frame_last;

  modport source (
    output valid, output vertex_index, output vertex_value,
    output left_valid, output left_weight, output up_valid,
    output up_weight, output frame_last, input ready
  );
  modport sink (
    input valid, input vertex_index, input vertex_value,
    input left_valid, input left_weight, input up_valid,
    input up_weight, input frame_last, output ready
  );

endinterface

// ===== sv/image_grid_edge_weights.sv =====
// ----------------------------------------------------------------------------
// image_grid_edge_weights
// Raster-order pixel stream to 4-connected grid graph vertices and edges.
// ----------------------------------------------------------------------------
// Takes one pixel per beat and returns one vertex per beat; each input beat
// passes through the weight stage registers and then the output register.
// The line store, a single memory of MAX_WIDTH entries, is read and written
// at the current column on every input beat; the upper neighbour comes out
// of its registered read together with the weight stage registers, and the
// weights are formed in front of the output register. Left edges are
// flagged off on the first column and upper edges on the first row. Weights
// carry one fractional bit: twice the absolute difference, or the sum, as
// chosen by weight_mode. Width and height of 0 act as 1, values above
// MAX_WIDTH or MAX_HEIGHT act as the maximum. Line store entries come out of
// reset unwritten; first-row beats read them before they are written, but
// their upper edges are flagged off.
// ----------------------------------------------------------------------------
module image_grid_edge_weights #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [igew_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [igew_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  igew_pixel_if.sink                          pix,
  igew_vertex_if.source                       vtx
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP  = (CW + 1 > igew_pkg::SIZE_BITS) ? CW + 1 : igew_pkg::SIZE_BITS;
  localparam int HCMP  = (RW + 1 > igew_pkg::SIZE_BITS) ? RW + 1 : igew_pkg::SIZE_BITS;
  localparam int PB    = igew_pkg::PIXEL_BITS;
  localparam int WB    = igew_pkg::WEIGHT_BITS;
  localparam int IB    = igew_pkg::INDEX_BITS;
  localparam int SB    = igew_pkg::SIZE_BITS;
  localparam logic [WCMP-1:0] WMAX = WCMP'(MAX_WIDTH);
  localparam logic [HCMP-1:0] HMAX = HCMP'(MAX_HEIGHT);

  // configuration
  logic [SB-1:0] image_width;
  logic [SB-1:0] image_height;
  logic          weight_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= igew_pkg::SIZE_RESET;
      image_height <= igew_pkg::SIZE_RESET;
      weight_mode  <= igew_pkg::MODE_DIFFERENCE;
    end else if (cfg_we) begin
      case (cfg_index)
        igew_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[SB-1:0];
        igew_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[SB-1:0];
        igew_pkg::REG_WEIGHT_MODE:  weight_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WCMP-1:0] width_ext;
  logic [HCMP-1:0] height_ext;
  logic [WCMP-1:0] width_eff;
  logic [HCMP-1:0] height_eff;

  assign width_ext  = WCMP'(image_width);
  assign height_ext = HCMP'(image_height);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = WCMP'(1);
    end else if (width_ext > WMAX) begin
      width_eff = WMAX;
    end else begin
      width_eff = width_ext;
    end
    if (height_ext == '0) begin
      height_eff = HCMP'(1);
    end else if (height_ext > HMAX) begin
      height_eff = HMAX;
    end else begin
      height_eff = height_ext;
    end
  end

  // input stage: counters and line store access
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [IB-1:0] vertex_count;
  logic [PB-1:0] left_pixel;
  logic          in_acc;
  logic          row_end;
  logic          frame_end;
  logic          advance;
  logic          s1_valid;

  assign pix.ready = !s1_valid || advance;
  assign in_acc    = pix.valid && pix.ready;
  assign row_end   = (WCMP'(column_count) + WCMP'(1)) >= width_eff;
  assign frame_end = row_end && ((HCMP'(row_count) + HCMP'(1)) >= height_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      vertex_count <= '0;
      left_pixel   <= '0;
    end else if (in_acc) begin
      left_pixel <= pix.pixel_value;
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        vertex_count <= '0;
      end else begin
        vertex_count <= vertex_count + IB'(1);
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + RW'(1);
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  logic [PB-1:0] row_store [MAX_WIDTH];
  logic [PB-1:0] up_pixel;

  // read-before-write: same-column beats see the previous row's sample
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_store[column_count] <= pix.pixel_value;
      up_pixel                <= row_store[column_count];
    end
  end

  // weight stage
  logic [PB-1:0] s1_pixel;
  logic [PB-1:0] s1_left;
  logic [IB-1:0] s1_index;
  logic          s1_lv;
  logic          s1_uv;
  logic          s1_last;
  logic          s1_mode;

  assign advance = !vtx.valid || vtx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel <= pix.pixel_value;
      s1_left  <= left_pixel;
      s1_index <= vertex_count;
      s1_lv    <= column_count != '0;
      s1_uv    <= row_count != '0;
      s1_last  <= frame_end;
      s1_mode  <= weight_mode;
    end
  end

  function automatic logic [WB-1:0] edge_weight(
    input logic [PB-1:0] p,
    input logic [PB-1:0] q,
    input logic          mode
  );
    logic [WB-1:0] abs_diff;
    abs_diff = (p >= q) ? WB'(p - q) : WB'(q - p);
    if (mode == igew_pkg::MODE_AVERAGE) begin
      edge_weight = WB'(p) + WB'(q);
    end else begin
      edge_weight = abs_diff << 1;
    end
  endfunction

  logic [WB-1:0] left_w;
  logic [WB-1:0] up_w;

  assign left_w = s1_lv ? edge_weight(s1_pixel, s1_left, s1_mode) : '0;
  assign up_w   = s1_uv ? edge_weight(s1_pixel, up_pixel, s1_mode) : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx.valid <= 1'b0;
    end else if (advance) begin
      vtx.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      vtx.vertex_index <= s1_index;
      vtx.vertex_value <= s1_pixel;
      vtx.left_valid   <= s1_lv;
      vtx.left_weight  <= left_w;
      vtx.up_valid     <= s1_uv;
      vtx.up_weight    <= up_w;
      vtx.frame_last   <= s1_last;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pix.ready |-> (s1_valid && vtx.valid))
    else $error("input stalled with free pipeline slot");

  // first-row reads hit unwritten entries, so only upper-edge beats are held to it
  a_up_data_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_uv && !advance) |=> $stable(up_pixel))
    else $error("line store read data lost while stalled");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && frame_end) |=> (column_count == '0 && row_count == '0 &&
                               vertex_count == '0))
    else $error("counters not cleared at frame end");

  a_first_column: assert property (@(posedge clk) disable iff (rst)
    (in_acc && column_count == '0) |=> (s1_valid && !s1_lv))
    else $error("left edge flagged on first column");

  a_weight_zero: assert property (@(posedge clk) disable iff (rst)
    (vtx.valid && !vtx.up_valid) |-> (vtx.up_weight == '0))
    else $error("upper weight set without upper edge");

endmodule
